// ===== sv/serial_audio_port_flags_defines.svh =====
// ---------------------------------------------------------------------------
// Serial audio port flags: assertion macros
// Shared assertion forms, clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef SERIAL_AUDIO_PORT_FLAGS_DEFINES_SVH
`define SERIAL_AUDIO_PORT_FLAGS_DEFINES_SVH

// A property that must hold at every clock edge out of reset.
`define SAPF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A condition that must never be seen at a clock edge out of reset.
`define SAPF_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== sv/sapf_pkg.sv =====
// ---------------------------------------------------------------------------
// Serial audio port flags package
// Field widths, command and register codes, flag positions and the structs
// shared between the configuration registers, the core and the output stage.
// ---------------------------------------------------------------------------
package sapf_pkg;

	localparam int FIELD_W         = 24;
	localparam int TX_PORTS        = 6;
	localparam int RX_PORTS        = 4;
	localparam int SLOT_W          = 5;
	localparam int FLAG_W          = 5;
	localparam int IRQ_W           = 5;
	localparam int DMA_W           = 2;
	localparam int CMD_W           = 2;
	localparam int CH_W            = 3;
	localparam int CFG_INDEX_W     = 2;
	localparam int CFG_DATA_W      = 6;
	localparam int DEF_TX_CHANNELS = 6;
	localparam int DEF_RX_CHANNELS = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_READ   = 2'd2,
		CMD_STATUS = 2'd3
	} cmd_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_TX_ENABLE  = 2'd0,
		CFG_RX_ENABLE  = 2'd1,
		CFG_LAST_SLOT  = 2'd2,
		CFG_IRQ_ENABLE = 2'd3
	} cfg_index_t;

	// Status flag positions.
	localparam int ST_TDE = 0;
	localparam int ST_TUE = 1;
	localparam int ST_TFS = 2;
	localparam int ST_RDF = 3;
	localparam int ST_ROE = 4;

	// Interrupt positions, shared by irq_enable and irq_raised.
	localparam int IRQ_RX_EXC  = 0;
	localparam int IRQ_RX_DATA = 1;
	localparam int IRQ_TX_EXC  = 2;
	localparam int IRQ_TX_LAST = 3;
	localparam int IRQ_TX_DATA = 4;

	// DMA request positions.
	localparam int DMA_TX = 0;
	localparam int DMA_RX = 1;

	typedef struct packed {
		logic [TX_PORTS-1:0] tx_enable;
		logic [RX_PORTS-1:0] rx_enable;
		logic [SLOT_W-1:0]   last_slot;
		logic [IRQ_W-1:0]    irq_enable;
	} cfg_t;

	typedef struct packed {
		logic [FIELD_W-1:0]                read_data;
		logic [FLAG_W-1:0]                 status;
		logic [TX_PORTS-1:0][FIELD_W-1:0]  tx_out;
		logic [IRQ_W-1:0]                  irq_raised;
		logic [DMA_W-1:0]                  dma_request;
	} result_t;

endpackage

// ===== sv/sapf_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// Serial audio port flags: configuration registers
// Holds the enable masks, the last slot and the interrupt enables. Every
// write transaction is taken in the cycle it is offered.
// ---------------------------------------------------------------------------
module sapf_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sapf_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [sapf_pkg::CFG_DATA_W-1:0]     cfg_data,
	output sapf_pkg::cfg_t                      cfg
);

	sapf_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (sapf_pkg::cfg_index_t'(cfg_index))
				sapf_pkg::CFG_TX_ENABLE: begin
					cfg_q.tx_enable <= cfg_data[sapf_pkg::TX_PORTS-1:0];
				end
				sapf_pkg::CFG_RX_ENABLE: begin
					cfg_q.rx_enable <= cfg_data[sapf_pkg::RX_PORTS-1:0];
				end
				sapf_pkg::CFG_LAST_SLOT: begin
					cfg_q.last_slot <= cfg_data[sapf_pkg::SLOT_W-1:0];
				end
				sapf_pkg::CFG_IRQ_ENABLE: begin
					cfg_q.irq_enable <= cfg_data[sapf_pkg::IRQ_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== sv/sapf_out_stage.sv =====
// ---------------------------------------------------------------------------
// Serial audio port flags: result register
// Holds one finished result until the receiver takes it, and accepts the
// next one in the same cycle the held one leaves.
// ---------------------------------------------------------------------------
module sapf_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  sapf_pkg::result_t load_data,
	output logic              load_ready,
	output logic              out_valid,
	input  logic              out_stall,
	output sapf_pkg::result_t result
);

	logic              valid_s2;
	sapf_pkg::result_t result_s2;

	assign load_ready = !valid_s2 || !out_stall;
	assign out_valid  = valid_s2;
	assign result     = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_ready) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_ready) begin
			result_s2 <= load_data;
		end
	end

endmodule

// ===== sv/sapf_core.sv =====
// ---------------------------------------------------------------------------
// Serial audio port flags: core
// Input register, channel word stores, flag and slot state, and the single
// pass of logic that turns one command into its result and next state.
// ---------------------------------------------------------------------------
`include "serial_audio_port_flags_defines.svh"

module sapf_core #(
	parameter int TX_CHANNELS = sapf_pkg::DEF_TX_CHANNELS,
	parameter int RX_CHANNELS = sapf_pkg::DEF_RX_CHANNELS
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  sapf_pkg::cfg_t                                    cfg,
	input  logic                                              in_valid,
	output logic                                              in_stall,
	input  logic [sapf_pkg::CMD_W-1:0]                        cmd,
	input  logic [sapf_pkg::CH_W-1:0]                         channel,
	input  logic [sapf_pkg::FIELD_W-1:0]                      write_data,
	input  logic [sapf_pkg::RX_PORTS-1:0][sapf_pkg::FIELD_W-1:0] rx_in,
	input  logic                                              load_ready,
	output logic                                              load,
	output sapf_pkg::result_t                                 load_data
);

	localparam int FW = sapf_pkg::FIELD_W;
	localparam int TP = sapf_pkg::TX_PORTS;
	localparam int RP = sapf_pkg::RX_PORTS;
	localparam int CW = sapf_pkg::CH_W;
	localparam int SW = sapf_pkg::SLOT_W;
	localparam int NW = 1 << CW;

	// Input register.
	logic                        valid_s1;
	sapf_pkg::cmd_t              cmd_s1;
	logic [CW-1:0]               channel_s1;
	logic [FW-1:0]               write_data_s1;
	logic [RP-1:0][FW-1:0]       rx_in_s1;

	// Block state.
	logic [FW-1:0]               tx_words_q [TX_CHANNELS];
	logic [FW-1:0]               rx_words_q [RX_CHANNELS];
	logic [TP-1:0]               tx_written_q;
	logic [RP-1:0]               rx_unread_q;
	logic [SW-1:0]               slot_q;
	logic [sapf_pkg::FLAG_W-1:0] flags_q;
	logic                        was_read_q;

	// Next state and decode.
	logic [TP-1:0]               tx_written_n;
	logic [RP-1:0]               rx_unread_n;
	logic [SW-1:0]               slot_n;
	logic [sapf_pkg::FLAG_W-1:0] flags_n;
	logic                        was_read_n;
	logic                        tx_store;
	logic                        rx_latch;
	logic [TP-1:0]               tem;
	logic [RP-1:0]               rem;
	logic [NW-1:0]               tem_wide;
	logic [NW-1:0]               rem_wide;
	logic [NW-1:0]               ch_onehot;
	logic [SW:0]                 slot_inc;
	logic                        fire;
	sapf_pkg::result_t           res;

	assign fire      = valid_s1 && load_ready;
	assign in_stall  = valid_s1 && !load_ready;
	assign load      = valid_s1;
	assign load_data = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1        <= sapf_pkg::cmd_t'(cmd);
			channel_s1    <= channel;
			write_data_s1 <= write_data;
			rx_in_s1      <= rx_in;
		end
	end

	always_comb begin
		for (int i = 0; i < TP; i++) begin
			tem[i] = cfg.tx_enable[i] && (i < TX_CHANNELS);
		end
		for (int i = 0; i < RP; i++) begin
			rem[i] = cfg.rx_enable[i] && (i < RX_CHANNELS);
		end
		tem_wide  = NW'(tem);
		rem_wide  = NW'(rem);
		ch_onehot = NW'(1) << channel_s1;
		slot_inc  = {1'b0, slot_q} + (SW + 1)'(1);
	end

	always_comb begin
		tx_written_n = tx_written_q;
		rx_unread_n  = rx_unread_q;
		slot_n       = slot_q;
		flags_n      = flags_q;
		was_read_n   = was_read_q;
		tx_store     = 1'b0;
		rx_latch     = 1'b0;
		res          = '0;

		unique case (cmd_s1)
			sapf_pkg::CMD_TICK: begin
				if (tem != '0) begin
					for (int i = 0; i < TX_CHANNELS; i++) begin
						res.tx_out[i] = tx_words_q[i];
					end
					if (tx_written_q != tem) begin
						flags_n[sapf_pkg::ST_TUE] = 1'b1;
					end
					flags_n[sapf_pkg::ST_TDE]         = 1'b1;
					tx_written_n                      = '0;
					res.dma_request[sapf_pkg::DMA_TX] = 1'b1;
				end
				if (rem != '0) begin
					if (rx_unread_q != '0) begin
						flags_n[sapf_pkg::ST_ROE] = 1'b1;
					end
					rx_latch                          = 1'b1;
					rx_unread_n                       = rem;
					flags_n[sapf_pkg::ST_RDF]         = 1'b1;
					res.dma_request[sapf_pkg::DMA_RX] = 1'b1;
				end
				flags_n[sapf_pkg::ST_TFS] = (slot_q == '0);
				// A counter left above a lowered last slot still wraps at this tick.
				slot_n = (slot_inc > {1'b0, cfg.last_slot}) ? '0 : slot_inc[SW-1:0];

				if (flags_n[sapf_pkg::ST_ROE]) begin
					if (cfg.irq_enable[sapf_pkg::IRQ_RX_EXC]) begin
						res.irq_raised[sapf_pkg::IRQ_RX_EXC] = 1'b1;
					end else begin
						flags_n[sapf_pkg::ST_ROE] = 1'b0;
					end
				end
				res.irq_raised[sapf_pkg::IRQ_RX_DATA] = cfg.irq_enable[sapf_pkg::IRQ_RX_DATA];
				if (flags_n[sapf_pkg::ST_TUE]) begin
					if (cfg.irq_enable[sapf_pkg::IRQ_TX_EXC]) begin
						res.irq_raised[sapf_pkg::IRQ_TX_EXC] = 1'b1;
					end else begin
						flags_n[sapf_pkg::ST_TUE] = 1'b0;
					end
				end
				res.irq_raised[sapf_pkg::IRQ_TX_LAST] = (slot_n == cfg.last_slot) &&
					cfg.irq_enable[sapf_pkg::IRQ_TX_LAST];
				res.irq_raised[sapf_pkg::IRQ_TX_DATA] = !flags_n[sapf_pkg::ST_TUE] &&
					cfg.irq_enable[sapf_pkg::IRQ_TX_DATA];
				was_read_n = 1'b0;
			end
			sapf_pkg::CMD_WRITE: begin
				if (tem_wide[channel_s1]) begin
					tx_store     = 1'b1;
					tx_written_n = tx_written_q | ch_onehot[TP-1:0];
					if (tx_written_n == tem) begin
						// Underrun clears only once the status has been read since the tick.
						if (was_read_q) begin
							flags_n[sapf_pkg::ST_TUE] = 1'b0;
						end
						flags_n[sapf_pkg::ST_TDE] = 1'b0;
					end
				end
			end
			sapf_pkg::CMD_READ: begin
				if (rem_wide[channel_s1]) begin
					rx_unread_n = rx_unread_q & ~ch_onehot[RP-1:0];
					if (rx_unread_n == '0) begin
						flags_n[sapf_pkg::ST_RDF] = 1'b0;
						flags_n[sapf_pkg::ST_ROE] = 1'b0;
					end
					for (int i = 0; i < RX_CHANNELS; i++) begin
						if (channel_s1 == CW'(i)) begin
							res.read_data = rx_words_q[i];
						end
					end
				end
			end
			sapf_pkg::CMD_STATUS: begin
				was_read_n    = 1'b1;
				res.read_data = FW'(flags_q);
			end
			default: begin
			end
		endcase

		res.status = flags_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TX_CHANNELS; i++) begin
				tx_words_q[i] <= '0;
			end
			for (int i = 0; i < RX_CHANNELS; i++) begin
				rx_words_q[i] <= '0;
			end
			tx_written_q <= '0;
			rx_unread_q  <= '0;
			slot_q       <= '0;
			flags_q      <= '0;
			was_read_q   <= 1'b0;
		end else if (fire) begin
			for (int i = 0; i < TX_CHANNELS; i++) begin
				if (tx_store && (channel_s1 == CW'(i))) begin
					tx_words_q[i] <= write_data_s1;
				end
			end
			for (int i = 0; i < RX_CHANNELS; i++) begin
				if (rx_latch) begin
					rx_words_q[i] <= rx_in_s1[i];
				end
			end
			tx_written_q <= tx_written_n;
			rx_unread_q  <= rx_unread_n;
			slot_q       <= slot_n;
			flags_q      <= flags_n;
			was_read_q   <= was_read_n;
		end
	end

	`SAPF_ASSERT(a_slot_wraps, (fire && cmd_s1 == sapf_pkg::CMD_TICK) |=> (slot_q <= $past(cfg.last_slot)), "slot counter left above last slot after a tick")
	`SAPF_ASSERT(a_tick_clears_written, (fire && cmd_s1 == sapf_pkg::CMD_TICK && tem != '0) |=> (tx_written_q == '0), "written mask not cleared by a transmit tick")
	`SAPF_ASSERT(a_status_read_marks, (fire && cmd_s1 == sapf_pkg::CMD_STATUS) |=> was_read_q, "status read not remembered")
	`SAPF_ASSERT_NEVER(a_requests_only_on_tick, valid_s1 && cmd_s1 != sapf_pkg::CMD_TICK && (res.irq_raised != '0 || res.dma_request != '0), "request raised outside a tick")

endmodule

// ===== sv/serial_audio_port_flags.sv =====
// ---------------------------------------------------------------------------
// Serial audio port flags: top level
// Slot ticks, transmit writes, receive reads and status reads on one command
// channel; one result per command; register writes on a port of their own.
// ---------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  cmd, channel, write_data, rx_in_0..3
//  out      output     out_valid/out_stall  read_data, status, tx_out_0..5, irq, dma
//  cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One command is taken every cycle while in_stall is low; its result passes
// through the input register and the result register, and can complete its
// own transaction once it is held in the result register.
// The result register frees in the cycle its transaction completes, so a
// stalled output holds back the input only when both registers are full.
// Reset clears all but held command and result data; cfg_ready is always high.
module serial_audio_port_flags #(
	parameter int TX_CHANNELS = sapf_pkg::DEF_TX_CHANNELS,
	parameter int RX_CHANNELS = sapf_pkg::DEF_RX_CHANNELS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sapf_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [sapf_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [sapf_pkg::CMD_W-1:0]        cmd,
	input  logic [sapf_pkg::CH_W-1:0]         channel,
	input  logic [sapf_pkg::FIELD_W-1:0]      write_data,
	input  logic [sapf_pkg::FIELD_W-1:0]      rx_in_0,
	input  logic [sapf_pkg::FIELD_W-1:0]      rx_in_1,
	input  logic [sapf_pkg::FIELD_W-1:0]      rx_in_2,
	input  logic [sapf_pkg::FIELD_W-1:0]      rx_in_3,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [sapf_pkg::FIELD_W-1:0]      read_data,
	output logic [sapf_pkg::FLAG_W-1:0]       status,
	output logic [sapf_pkg::FIELD_W-1:0]      tx_out_0,
	output logic [sapf_pkg::FIELD_W-1:0]      tx_out_1,
	output logic [sapf_pkg::FIELD_W-1:0]      tx_out_2,
	output logic [sapf_pkg::FIELD_W-1:0]      tx_out_3,
	output logic [sapf_pkg::FIELD_W-1:0]      tx_out_4,
	output logic [sapf_pkg::FIELD_W-1:0]      tx_out_5,
	output logic [sapf_pkg::IRQ_W-1:0]        irq_raised,
	output logic [sapf_pkg::DMA_W-1:0]        dma_request
);

	sapf_pkg::cfg_t                                         cfg;
	logic [sapf_pkg::RX_PORTS-1:0][sapf_pkg::FIELD_W-1:0]  rx_in;
	logic                                                   load;
	logic                                                   load_ready;
	sapf_pkg::result_t                                      load_data;
	sapf_pkg::result_t                                      result;

	assign rx_in[0] = rx_in_0;
	assign rx_in[1] = rx_in_1;
	assign rx_in[2] = rx_in_2;
	assign rx_in[3] = rx_in_3;

	sapf_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sapf_core #(
		.TX_CHANNELS (TX_CHANNELS),
		.RX_CHANNELS (RX_CHANNELS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.channel    (channel),
		.write_data (write_data),
		.rx_in      (rx_in),
		.load_ready (load_ready),
		.load       (load),
		.load_data  (load_data)
	);

	sapf_out_stage u_out_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.load_data  (load_data),
		.load_ready (load_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result     (result)
	);

	assign read_data   = result.read_data;
	assign status      = result.status;
	assign tx_out_0    = result.tx_out[0];
	assign tx_out_1    = result.tx_out[1];
	assign tx_out_2    = result.tx_out[2];
	assign tx_out_3    = result.tx_out[3];
	assign tx_out_4    = result.tx_out[4];
	assign tx_out_5    = result.tx_out[5];
	assign irq_raised  = result.irq_raised;
	assign dma_request = result.dma_request;

endmodule

// ===== tb/serial_audio_port_flags_tb.sv =====
// ---------------------------------------------------------------------------
// Serial audio port flags: regression testbench
// Drives ticks, transmit writes, receive reads and status reads under several
// register settings, predicts every response from a cycle-free model of the
// port, and compares each response field by field under random idling.
// ---------------------------------------------------------------------------
module testbench;
	import sapf_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 88;
	localparam int LONG_HOLD   = 80;

	typedef struct packed {
		cmd_t                          op;
		logic [CH_W-1:0]               channel;
		logic [FIELD_W-1:0]            write_data;
		logic [RX_PORTS-1:0][FIELD_W-1:0] rx_in;
	} port_cmd_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_index_t            cfg_index = CFG_TX_ENABLE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	port_cmd_t             cur_item = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [FIELD_W-1:0]    read_data;
	logic [FLAG_W-1:0]     status;
	logic [FIELD_W-1:0]    tx_out_0, tx_out_1, tx_out_2, tx_out_3, tx_out_4, tx_out_5;
	logic [IRQ_W-1:0]      irq_raised;
	logic [DMA_W-1:0]      dma_request;

	// Register copies and port state as the block should hold them.
	logic [TX_PORTS-1:0] tx_mask_cfg = '0;
	logic [RX_PORTS-1:0] rx_mask_cfg = '0;
	logic [SLOT_W-1:0]   frame_last = '0;
	logic [IRQ_W-1:0]    irq_mask_cfg = '0;
	logic [FIELD_W-1:0]  tx_slot_word [TX_PORTS] = '{default: '0};
	logic [FIELD_W-1:0]  rx_slot_word [RX_PORTS] = '{default: '0};
	logic [TX_PORTS-1:0] tx_loaded = '0;
	logic [RX_PORTS-1:0] rx_pending = '0;
	logic [SLOT_W-1:0]   slot_pos = '0;
	logic [FLAG_W-1:0]   port_flags = '0;
	logic                flags_seen = 1'b0;

	port_cmd_t command_queue [$];
	result_t   port_responses [$];

	int   items_pushed = 0;
	int   items_taken = 0;
	int   responses_checked = 0;
	int   mismatch_count = 0;
	int   cycle_count = 0;
	int   phase_count = 0;
	int   send_gap = 0;
	int   recv_gap = 0;
	int   long_hold_left = 0;
	logic calm = 1'b0;
	logic want_long_hold = 1'b0;
	logic long_hold_done = 1'b0;
	logic in_took = 1'b0;

	serial_audio_port_flags u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cur_item.op),
		.channel     (cur_item.channel),
		.write_data  (cur_item.write_data),
		.rx_in_0     (cur_item.rx_in[0]),
		.rx_in_1     (cur_item.rx_in[1]),
		.rx_in_2     (cur_item.rx_in[2]),
		.rx_in_3     (cur_item.rx_in[3]),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_data   (read_data),
		.status      (status),
		.tx_out_0    (tx_out_0),
		.tx_out_1    (tx_out_1),
		.tx_out_2    (tx_out_2),
		.tx_out_3    (tx_out_3),
		.tx_out_4    (tx_out_4),
		.tx_out_5    (tx_out_5),
		.irq_raised  (irq_raised),
		.dma_request (dma_request)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Applies one command to the port state and returns the response it causes.
	function automatic result_t audio_port_step(port_cmd_t c);
		result_t           r;
		logic [SLOT_W:0]   slot_next;
		r = '0;
		case (c.op)
			CMD_TICK: begin
				if (tx_mask_cfg != '0) begin
					for (int i = 0; i < TX_PORTS; i++)
						r.tx_out[i] = tx_slot_word[i];
					if (tx_loaded != tx_mask_cfg)
						port_flags[ST_TUE] = 1'b1;
					port_flags[ST_TDE] = 1'b1;
					tx_loaded = '0;
					r.dma_request[DMA_TX] = 1'b1;
				end
				if (rx_mask_cfg != '0) begin
					if (rx_pending != '0)
						port_flags[ST_ROE] = 1'b1;
					for (int i = 0; i < RX_PORTS; i++)
						rx_slot_word[i] = c.rx_in[i];
					rx_pending = rx_mask_cfg;
					port_flags[ST_RDF] = 1'b1;
					r.dma_request[DMA_RX] = 1'b1;
				end
				port_flags[ST_TFS] = (slot_pos == '0);
				slot_next = {1'b0, slot_pos} + 1'b1;
				slot_pos = (slot_next > {1'b0, frame_last}) ? '0 : slot_next[SLOT_W-1:0];
				// Exception flags survive only while their interrupt is enabled.
				if (port_flags[ST_ROE]) begin
					if (irq_mask_cfg[IRQ_RX_EXC])
						r.irq_raised[IRQ_RX_EXC] = 1'b1;
					else
						port_flags[ST_ROE] = 1'b0;
				end
				if (irq_mask_cfg[IRQ_RX_DATA])
					r.irq_raised[IRQ_RX_DATA] = 1'b1;
				if (port_flags[ST_TUE]) begin
					if (irq_mask_cfg[IRQ_TX_EXC])
						r.irq_raised[IRQ_TX_EXC] = 1'b1;
					else
						port_flags[ST_TUE] = 1'b0;
				end
				if (slot_pos == frame_last && irq_mask_cfg[IRQ_TX_LAST])
					r.irq_raised[IRQ_TX_LAST] = 1'b1;
				if (!port_flags[ST_TUE] && irq_mask_cfg[IRQ_TX_DATA])
					r.irq_raised[IRQ_TX_DATA] = 1'b1;
				flags_seen = 1'b0;
			end
			CMD_WRITE: begin
				if (c.channel < TX_PORTS) begin
					if (tx_mask_cfg[c.channel]) begin
						tx_slot_word[c.channel] = c.write_data;
						tx_loaded[c.channel] = 1'b1;
						if (tx_loaded == tx_mask_cfg) begin
							if (flags_seen)
								port_flags[ST_TUE] = 1'b0;
							port_flags[ST_TDE] = 1'b0;
						end
					end
				end
			end
			CMD_READ: begin
				if (c.channel < RX_PORTS) begin
					if (rx_mask_cfg[c.channel]) begin
						rx_pending[c.channel] = 1'b0;
						if (rx_pending == '0) begin
							port_flags[ST_RDF] = 1'b0;
							port_flags[ST_ROE] = 1'b0;
						end
						r.read_data = rx_slot_word[c.channel];
					end
				end
			end
			default: begin
				flags_seen = 1'b1;
				r.read_data = FIELD_W'(port_flags);
			end
		endcase
		r.status = port_flags;
		return r;
	endfunction

	function automatic void check_field(string name, logic [FIELD_W-1:0] want,
		logic [FIELD_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	function automatic logic [RX_PORTS-1:0][FIELD_W-1:0] rand_rx();
		return {24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom)};
	endfunction

	task automatic push_cmd(cmd_t op, int ch, logic [FIELD_W-1:0] wd,
		logic [RX_PORTS-1:0][FIELD_W-1:0] rx);
		port_cmd_t c;
		c.op = op;
		c.channel = CH_W'(ch);
		c.write_data = wd;
		c.rx_in = rx;
		command_queue = {command_queue, c};
		items_pushed++;
	endtask

	task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_TX_ENABLE:  tx_mask_cfg = val[TX_PORTS-1:0];
			CFG_RX_ENABLE:  rx_mask_cfg = val[RX_PORTS-1:0];
			CFG_LAST_SLOT:  frame_last = val[SLOT_W-1:0];
			CFG_IRQ_ENABLE: irq_mask_cfg = val[IRQ_W-1:0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_port(logic [5:0] tx, logic [5:0] rx, logic [5:0] last,
		logic [5:0] irq);
		write_reg(CFG_TX_ENABLE, tx);
		write_reg(CFG_RX_ENABLE, rx);
		write_reg(CFG_LAST_SLOT, last);
		write_reg(CFG_IRQ_ENABLE, irq);
		phase_count++;
	endtask

	// Waits until every command has completed its transaction and every
	// response has been checked, then lets the pipeline settle.
	task automatic wait_idle();
		@(negedge clk);
		while (items_taken != items_pushed || port_responses.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// One frame's worth of traffic: fill the transmit slots, tick, drain the
	// receive slots. A few accesses are skipped to provoke under- and overrun.
	task automatic queue_frame();
		if ($urandom_range(0, 2) == 0)
			push_cmd(CMD_STATUS, $urandom_range(0, 7), 24'($urandom), rand_rx());
		for (int ch = 0; ch < TX_PORTS; ch++) begin
			if (tx_mask_cfg[ch] && $urandom_range(0, 9) != 0)
				push_cmd(CMD_WRITE, ch, 24'($urandom), rand_rx());
		end
		if ($urandom_range(0, 3) == 0)
			push_cmd(CMD_STATUS, $urandom_range(0, 7), 24'($urandom), rand_rx());
		push_cmd(CMD_TICK, $urandom_range(0, 7), 24'($urandom), rand_rx());
		for (int ch = 0; ch < RX_PORTS; ch++) begin
			if (rx_mask_cfg[ch] && $urandom_range(0, 7) != 0)
				push_cmd(CMD_READ, ch, 24'($urandom), rand_rx());
		end
	endtask

	// Command driver: a new command is presented only once the previous one
	// has completed its transaction.
	always @(negedge clk) begin
		if (!in_valid || in_took) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (command_queue.size() > 0) begin
				cur_item <= command_queue.pop_front();
				in_valid <= 1'b1;
				if (!calm && $urandom_range(0, 7) == 0)
					send_gap = $urandom_range(1, 10);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Response side back-pressure, including one long hold-off.
	always @(negedge clk) begin
		if (long_hold_left > 0) begin
			long_hold_left--;
			out_stall <= 1'b1;
		end else if (want_long_hold && !long_hold_done) begin
			long_hold_left = LONG_HOLD;
			long_hold_done = 1'b1;
			out_stall <= 1'b1;
		end else if (recv_gap > 0) begin
			recv_gap--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (!calm && $urandom_range(0, 5) == 0)
				recv_gap = $urandom_range(1, 10);
		end
	end

	always @(posedge clk) begin
		result_t want;
		in_took <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			port_responses = {port_responses, audio_port_step(cur_item)};
			items_taken++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (port_responses.size() == 0) begin
				$error("response transaction with no command outstanding");
				mismatch_count++;
			end else begin
				want = port_responses.pop_front();
				check_field("read_data", want.read_data, read_data);
				check_field("status", FIELD_W'(want.status), FIELD_W'(status));
				check_field("tx_out_0", want.tx_out[0], tx_out_0);
				check_field("tx_out_1", want.tx_out[1], tx_out_1);
				check_field("tx_out_2", want.tx_out[2], tx_out_2);
				check_field("tx_out_3", want.tx_out[3], tx_out_3);
				check_field("tx_out_4", want.tx_out[4], tx_out_4);
				check_field("tx_out_5", want.tx_out[5], tx_out_5);
				check_field("irq_raised", FIELD_W'(want.irq_raised), FIELD_W'(irq_raised));
				check_field("dma_request", FIELD_W'(want.dma_request),
					FIELD_W'(dma_request));
				responses_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("serial_audio_port_flags regression: fail");
			$finish;
		end
	end

	initial begin
		logic [FIELD_W-1:0] patterns [TX_PORTS];
		int                 start;
		patterns = '{24'h000000, 24'hFFFFFF, 24'hA5A5A5, 24'h5A5A5A, 24'h000001,
			24'h800000};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Everything disabled after reset: channel writes and reads must be ignored.
		phase_count++;
		push_cmd(CMD_TICK, 0, 24'h0, {4{24'hFFFFFF}});
		push_cmd(CMD_WRITE, 0, 24'hFFFFFF, '0);
		push_cmd(CMD_READ, 0, 24'h0, '0);
		push_cmd(CMD_STATUS, 0, 24'h0, '0);
		wait_idle();

		// All channels on; the receive mask is written with bits beyond its width.
		set_port(6'd63, 6'd63, 6'd3, 6'd31);
		push_cmd(CMD_STATUS, 0, 24'h0, '0);
		for (int ch = 0; ch < TX_PORTS; ch++)
			push_cmd(CMD_WRITE, ch, patterns[ch], '0);
		push_cmd(CMD_WRITE, 7, 24'hFFFFFF, '0);
		push_cmd(CMD_TICK, 0, 24'h0, {24'hAAAAAA, 24'h555555, 24'h000000, 24'hFFFFFF});
		for (int ch = 0; ch < RX_PORTS; ch++)
			push_cmd(CMD_READ, ch, 24'h0, '0);
		push_cmd(CMD_READ, 4, 24'h0, '0);
		push_cmd(CMD_READ, 7, 24'h0, '0);
		// No writes since the last tick: underrun, and the old words go out again.
		push_cmd(CMD_TICK, 7, 24'h0, {4{24'h123456}});
		// Nothing read since the last tick: overrun.
		push_cmd(CMD_TICK, 0, 24'h0, {4{24'hFEDCBA}});
		push_cmd(CMD_STATUS, 0, 24'h0, '0);
		wait_idle();

		// Lowering the frame length while the slot counter is past the new end.
		set_port(6'h15, 6'h05, 6'd63, 6'd0);
		repeat (5) push_cmd(CMD_TICK, 0, 24'h0, rand_rx());
		wait_idle();
		write_reg(CFG_LAST_SLOT, 6'd2);
		repeat (2) push_cmd(CMD_TICK, 0, 24'h0, rand_rx());
		wait_idle();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: set_port(6'd63, 6'd15, 6'd0, 6'd31);
				1: set_port(6'd0, 6'd63, 6'd1, 6'($urandom));
				2: set_port(6'd63, 6'd0, 6'd31, 6'($urandom));
				default: set_port(6'($urandom), 6'($urandom),
					($urandom_range(0, 5) == 0) ? 6'd63 : 6'($urandom_range(0, 7)),
					6'($urandom));
			endcase
			if (p == 7)
				calm = 1'b1;
			start = items_pushed;
			while (items_pushed - start < PHASE_ITEMS) begin
				if ($urandom_range(0, 4) == 0)
					push_cmd(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 7),
						24'($urandom), rand_rx());
				else
					queue_frame();
			end
			// Hold the response side long enough for the block to back up.
			if (p == 3)
				want_long_hold = 1'b1;
			wait_idle();
		end

		$display("covered %0d commands under %0d register settings", items_pushed,
			phase_count);
		$display("checked %0d responses, %0d field mismatches", responses_checked,
			mismatch_count);
		if (mismatch_count == 0) begin
			$display("serial_audio_port_flags regression: pass");
		end else begin
			$display("serial_audio_port_flags regression: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/sapf_pkg.sv
sv/sapf_cfg_regs.sv
sv/sapf_out_stage.sv
sv/sapf_core.sv
sv/serial_audio_port_flags.sv
tb/serial_audio_port_flags_tb.sv
